// ===== sv/bm3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bm3_pkg;

	// geometry
	localparam int MAX_WIDTH_DFLT = 1024;
	localparam int KERNEL_SIZE    = 3;
	localparam int WIN_BITS       = KERNEL_SIZE * KERNEL_SIZE;
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int ROW_W          = 12;
	localparam int QUEUE_DEPTH    = 4;

	// register file
	localparam int CFG_DATA_W = 13;
	localparam logic [1:0] REG_MASK   = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	localparam logic [WIN_BITS-1:0] MASK_RST   = '1;
	localparam logic [10:0]         WIDTH_RST  = 11'd640;
	localparam logic [12:0]         HEIGHT_RST = 13'd480;

	// morphology operation
	localparam logic MODE_ERODE  = 1'b0;
	localparam logic MODE_DILATE = 1'b1;

	localparam logic [7:0] PIX_SET = 8'hFF;
	localparam logic [7:0] PIX_CLR = 8'h00;

	// what the front end hands to the back end for one pixel
	typedef struct packed {
		logic cur;       // pixel is set
		logic emit;      // a result is produced
		logic interior;  // result comes from the window, not the border
		logic last;      // final result of the frame
	} cls_t;

endpackage

`default_nettype wire

// ===== sv/binary_morphology_3x3_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 3x3 binary erosion / dilation over a raster pixel stream. a pixel counts
// as set only when it is 255; the structuring element is a 9-bit mask
// (bit 3*row+col). for every pixel at (r,c) with r,c >= 1 one result for
// (r-1,c-1) comes out, 0 or 255, with border results forced to 0 and
// frame_last marking the final result of a frame. sustained rate is one
// pixel per clock while the output is not stalled: a front end tracks the
// raster position and classifies each pixel, a four-entry queue decouples
// it from the back end, which reads the line store, slides the window and
// fills the output register. after reset the line store is cleared one
// entry per clock, and in_stall stays high until the clear is done;
// configuration writes are taken during that time. configuration may only
// be changed while the stream is idle.

module binary_morphology_3x3_top import bm3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DFLT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_wr_en,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// pixel input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            pixel_in,
	// result output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 pixel_out,
	output logic                       frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = CW + $bits(cls_t);

	// configuration registers
	logic [WIN_BITS-1:0] mask_q;
	logic                mode_q;
	logic [10:0]         width_q;
	logic [12:0]         height_q;

	// front to queue
	logic                push;
	cls_t                f_cls;
	logic [CW-1:0]       f_col;

	// queue to back
	logic [QW-1:0]       q_head;
	cls_t                q_cls;
	logic [CW-1:0]       q_col;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;
	logic                busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= MASK_RST;
			mode_q   <= MODE_ERODE;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MASK:   mask_q   <= cfg_wdata[WIN_BITS-1:0];
				REG_MODE:   mode_q   <= cfg_wdata[0];
				REG_WIDTH:  width_q  <= cfg_wdata[10:0];
				REG_HEIGHT: height_q <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	// front end: input handshake, raster position, classification
	bm3_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.pixel_in    (pixel_in),
		.busy        (busy),
		.q_full      (q_full),
		.image_width (width_q),
		.image_height(height_q),
		.in_stall    (in_stall),
		.push        (push),
		.cls         (f_cls),
		.col         (f_col)
	);

	// short queue between the two halves
	bm3_fifo #(
		.DATA_W(QW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({f_col, f_cls}),
		.pop   (q_pop),
		.rdata (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	assign q_col = q_head[QW-1 -: CW];
	assign q_cls = cls_t'(q_head[$bits(cls_t)-1:0]);

	// back end: line store, window, morphology, output register
	bm3_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cls     (q_cls),
		.q_col     (q_col),
		.mask_bits (mask_q),
		.morph_mode(mode_q),
		.out_stall (out_stall),
		.q_pop     (q_pop),
		.busy      (busy),
		.out_valid (out_valid),
		.pixel_out (pixel_out),
		.frame_last(frame_last)
	);

	// no result can appear while the line store is still being cleared
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !out_valid)
		else $error("result while line store clear is running");

	// results are strictly binary
	a_binary_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_out == PIX_SET || pixel_out == PIX_CLR))
		else $error("result pixel is neither 0 nor 255");

	// the queue never holds an item while the clear is running
	a_queue_idle_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_empty)
		else $error("queue holds a transaction during line store clear");

endmodule

`default_nettype wire

// ===== sv/bm3_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bm3_front import bm3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DFLT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [7:0]                   pixel_in,
	input  wire logic                         busy,
	input  wire logic                         q_full,
	input  wire logic [10:0]                  image_width,
	input  wire logic [12:0]                  image_height,
	output logic                              in_stall,
	output logic                              push,
	output cls_t                              cls,
	output logic [$clog2(MAX_WIDTH)-1:0]      col
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    wlast;
	logic [ROW_W-1:0] hlast;
	logic             col_end;
	logic             row_end;

	// clamp geometry to the supported range
	always_comb begin
		if (image_width < 11'd3)
			wlast = CW'(2);
		else if (int'(image_width) >= MAX_WIDTH)
			wlast = CW'(MAX_WIDTH - 1);
		else
			wlast = CW'(image_width - 11'd1);
	end

	always_comb begin
		if (image_height < 13'd3)
			hlast = ROW_W'(2);
		else if (int'(image_height) >= HEIGHT_LIMIT)
			hlast = ROW_W'(HEIGHT_LIMIT - 1);
		else
			hlast = ROW_W'(image_height - 13'd1);
	end

	assign col_end  = (col_q >= wlast);
	assign row_end  = (row_q >= hlast);

	assign in_stall = busy | q_full;
	assign push     = in_valid & ~in_stall;
	assign col      = col_q;

	always_comb begin
		cls.cur      = (pixel_in == PIX_SET);
		cls.emit     = (row_q != '0) && (col_q != '0);
		cls.interior = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
		cls.last     = row_end & col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/bm3_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bm3_fifo import bm3_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      rdata,
	output logic                   full,
	output logic                   empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [NW-1:0]     cnt_q;
	logic              do_pop;

	assign full   = (cnt_q == NW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rdata  = slot_q[rd_q];
	assign do_pop = pop & ~empty;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + NW'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - NW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== sv/bm3_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bm3_back import bm3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DFLT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire cls_t                          q_cls,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_col,
	input  wire logic [WIN_BITS-1:0]           mask_bits,
	input  wire logic                          morph_mode,
	input  wire logic                          out_stall,
	output logic                               q_pop,
	output logic                               busy,
	output logic                               out_valid,
	output logic [7:0]                         pixel_out,
	output logic                               frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);

	// line store: bit 1 two rows back, bit 0 one row back
	logic [1:0]          line_mem [MAX_WIDTH];
	logic [1:0]          rd_s1;
	cls_t                cls_s1;
	logic [CW-1:0]       col_s1;
	logic                vld_s1;

	logic [WIN_BITS-1:0] win_q;
	logic [WIN_BITS-1:0] win_nxt;
	logic [WIN_BITS-1:0] hit;
	logic                on;

	logic                init_q;
	logic [CW-1:0]       clr_q;

	logic                out_v_q;
	logic [7:0]          pix_q;
	logic                last_q;

	logic                exec_ok;
	logic                adv;
	logic                exec;

	assign exec_ok = ~cls_s1.emit | ~out_v_q | ~out_stall;
	assign adv     = ~vld_s1 | exec_ok;
	assign exec    = vld_s1 & exec_ok;
	assign q_pop   = adv & ~q_empty & ~init_q;
	assign busy    = init_q;

	// slide one column, newest column enters at the right
	assign win_nxt = {cls_s1.cur, win_q[8:7], rd_s1[0], win_q[5:4], rd_s1[1], win_q[2:1]};
	assign hit     = win_nxt & mask_bits;
	assign on      = (morph_mode == MODE_ERODE) ? (hit == mask_bits) : (hit != '0);

	always_ff @(posedge clk) begin
		if (init_q)
			line_mem[clr_q] <= 2'b00;
		else if (exec)
			line_mem[col_s1] <= {rd_s1[0], cls_s1.cur};
		if (q_pop)
			rd_s1 <= line_mem[q_col];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cls_s1 <= q_cls;
			col_s1 <= q_col;
		end
		if (exec && cls_s1.emit) begin
			pix_q  <= (cls_s1.interior && on) ? PIX_SET : PIX_CLR;
			last_q <= cls_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 1'b1;
			clr_q   <= '0;
			vld_s1  <= 1'b0;
			win_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (init_q) begin
				clr_q <= clr_q + CW'(1);
				if (clr_q == CW'(MAX_WIDTH - 1))
					init_q <= 1'b0;
			end
			if (adv)
				vld_s1 <= q_pop;
			if (exec)
				win_q <= win_nxt;
			if (exec && cls_s1.emit)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	assign out_valid  = out_v_q;
	assign pixel_out  = pix_q;
	assign frame_last = last_q;

endmodule

`default_nettype wire
